@@ rtl/core/i2crtc_pkg.sv @@
`timescale 1ns / 1ps

package i2crtc_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [6:0]  DEV_ADDR_RST    = 7'd104;
	localparam logic [9:0]  ACK_TIMEOUT_RST = 10'd500;
	localparam logic [15:0] SETTLE_RST      = 16'd800;

	// Number of entries in the polling rotation and number of real time fields.
	localparam int FIELD_COUNT = 6;
	localparam int TIME_FIELDS = 6;

	typedef enum logic [1:0] {
		REG_DEVICE_ADDRESS = 2'd0,
		REG_ACK_TIMEOUT    = 2'd1,
		REG_SETTLE_TICKS   = 2'd2
	} reg_e;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_POLL  = 2'd3
	} op_e;

	typedef enum logic [3:0] {
		SEG_IDLE   = 4'd0,
		SEG_START  = 4'd1,
		SEG_TXW    = 4'd2,
		SEG_TXR    = 4'd3,
		SEG_TXREG  = 4'd4,
		SEG_TXDATA = 4'd5,
		SEG_RX     = 4'd6,
		SEG_STOP   = 4'd7,
		SEG_SETTLE = 4'd8,
		SEG_DONE   = 4'd9
	} seg_e;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [9:0]  ack_timeout;
		logic [15:0] write_settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
		logic [2:0] field_index;
		logic       poll_wrapped;
		logic       ack_error;
	} result_t;

	typedef struct packed {
		seg_e       phase;
		logic [2:0] seq;
		logic [7:0] shift;
	} entry_t;

	typedef struct packed {
		logic [2:0] q;
		logic [1:0] r;
	} div3_t;

	function automatic seg_e plan_write(logic [2:0] seq);
		seg_e s;
		unique case (seq)
			3'd0: s = SEG_START;
			3'd1: s = SEG_TXW;
			3'd2: s = SEG_TXREG;
			3'd3: s = SEG_TXDATA;
			3'd4: s = SEG_STOP;
			3'd5: s = SEG_SETTLE;
			default: s = SEG_DONE;
		endcase
		return s;
	endfunction

	function automatic seg_e plan_read(logic [2:0] seq);
		seg_e s;
		unique case (seq)
			3'd0: s = SEG_START;
			3'd1: s = SEG_TXW;
			3'd2: s = SEG_TXREG;
			3'd3: s = SEG_START;
			3'd4: s = SEG_TXR;
			3'd5: s = SEG_RX;
			3'd6: s = SEG_STOP;
			default: s = SEG_DONE;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] time_reg(logic [2:0] idx);
		logic [7:0] a;
		case (idx)
			3'd0: a = 8'd0;
			3'd1: a = 8'd1;
			3'd2: a = 8'd2;
			3'd3: a = 8'd4;
			3'd4: a = 8'd5;
			3'd5: a = 8'd6;
			default: a = 8'd0;
		endcase
		return a;
	endfunction

	// Quotient and remainder by three for values up to 23, by reciprocal multiply.
	function automatic div3_t div3(logic [4:0] x);
		logic [8:0] p;
		div3_t d;
		p = 9'(x) * 9'd11;
		d.q = p[7:5];
		d.r = 2'(x - 5'(d.q) * 5'd3);
		return d;
	endfunction

	function automatic logic [7:0] bcd_to_bin(logic [7:0] b);
		return 8'({4'b0, b[7:4]} * 8'd10 + {4'b0, b[3:0]});
	endfunction

	// A settle segment of zero length is skipped straight to the next one.
	function automatic entry_t enter_seg(op_e op, logic [2:0] seq, cfg_t cfg,
			logic [7:0] sreg, logic [7:0] sdata, logic [7:0] shift);
		entry_t e;
		logic [2:0] s;
		s = seq;
		e.phase = (op == OP_WRITE) ? plan_write(s) : plan_read(s);
		if (e.phase == SEG_SETTLE && cfg.write_settle_ticks == '0) begin
			s = s + 3'd1;
			e.phase = (op == OP_WRITE) ? plan_write(s) : plan_read(s);
		end
		e.seq = s;
		case (e.phase)
			SEG_TXW:    e.shift = {cfg.device_address, 1'b0};
			SEG_TXR:    e.shift = {cfg.device_address, 1'b1};
			SEG_TXREG:  e.shift = sreg;
			SEG_TXDATA: e.shift = sdata;
			SEG_RX:     e.shift = 8'd0;
			default:    e.shift = shift;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/core/i2crtc_cfg.sv @@
`timescale 1ns / 1ps

module i2crtc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2crtc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [i2crtc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [i2crtc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready,
	output i2crtc_pkg::cfg_t                    cfg
);
	import i2crtc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	reg_e sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = reg_e'(paddr[APB_ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address     <= DEV_ADDR_RST;
			cfg_q.ack_timeout        <= ACK_TIMEOUT_RST;
			cfg_q.write_settle_ticks <= SETTLE_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_DEVICE_ADDRESS: cfg_q.device_address     <= pwdata[6:0];
				REG_ACK_TIMEOUT:    cfg_q.ack_timeout        <= pwdata[9:0];
				REG_SETTLE_TICKS:   cfg_q.write_settle_ticks <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_DEVICE_ADDRESS: prdata = {25'd0, cfg_q.device_address};
			REG_ACK_TIMEOUT:    prdata = {22'd0, cfg_q.ack_timeout};
			REG_SETTLE_TICKS:   prdata = {16'd0, cfg_q.write_settle_ticks};
			default:            prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/i2crtc_engine.sv @@
`timescale 1ns / 1ps

module i2crtc_engine #(
	parameter int FIELD_COUNT = i2crtc_pkg::FIELD_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  i2crtc_pkg::item_t    item,
	input  i2crtc_pkg::cfg_t     cfg,
	output i2crtc_pkg::result_t  res
);
	import i2crtc_pkg::*;

	seg_e       phase_q, phase_d, cur_phase;
	logic [2:0] seq_q, seq_d, cur_seq;
	logic [4:0] pos_q, pos_d, cur_pos;
	logic [15:0] wait_q, wait_d, cur_wait;
	op_e        op_q, op_d, cur_op, start_op;
	logic [7:0] shift_q, shift_d, cur_shift;
	logic [7:0] sreg_q, sreg_d, cur_sreg, start_sreg;
	logic [7:0] sdata_q, sdata_d, cur_sdata;
	logic [7:0] rbyte_q, rbyte_d;
	logic       err_q, err_d;
	logic [2:0] poll_q, poll_d, field_q, field_d;
	logic       scl_q, scl_d, drv_q, drv_d, lvl_q, lvl_d;

	logic       start_go, adv_seg, busy, done;
	logic [2:0] start_seq, poll_inc;
	logic       poll_wrap;
	logic [9:0] ack_thr;
	entry_t     first, next_seg;
	div3_t      tx_slot, rx_slot;

	assign start_op  = op_e'(item.mode);
	assign start_go  = (phase_q == SEG_IDLE) && (start_op != OP_TICK);
	assign start_seq = (start_op == OP_POLL && {1'b0, poll_q} >= 4'(TIME_FIELDS)) ? 3'd7 : 3'd0;
	assign start_sreg = (start_op == OP_POLL && {1'b0, poll_q} < 4'(TIME_FIELDS)) ?
			time_reg(poll_q) : item.reg_addr;
	assign first = enter_seg(start_op, start_seq, cfg, start_sreg, item.write_data, shift_q);

	always_comb begin
		if (start_go) begin
			cur_phase = first.phase;
			cur_seq   = first.seq;
			cur_shift = first.shift;
			cur_op    = start_op;
			cur_sreg  = start_sreg;
			cur_sdata = item.write_data;
			cur_pos   = '0;
			cur_wait  = '0;
		end else begin
			cur_phase = phase_q;
			cur_seq   = seq_q;
			cur_shift = shift_q;
			cur_op    = op_q;
			cur_sreg  = sreg_q;
			cur_sdata = sdata_q;
			cur_pos   = pos_q;
			cur_wait  = wait_q;
		end
	end

	assign next_seg  = enter_seg(cur_op, cur_seq + 3'd1, cfg, cur_sreg, cur_sdata, cur_shift);
	assign tx_slot   = div3(cur_pos - 5'd2);
	assign rx_slot   = div3(cur_pos - 5'd1);
	assign ack_thr   = (cfg.ack_timeout != '0) ? cfg.ack_timeout - 10'd1 : 10'd0;
	assign poll_inc  = poll_q + 3'd1;
	assign poll_wrap = ({1'b0, poll_inc} >= 4'(FIELD_COUNT)) || (poll_inc == 3'd0);

	always_comb begin
		phase_d = cur_phase;
		seq_d   = cur_seq;
		pos_d   = cur_pos;
		wait_d  = cur_wait;
		op_d    = cur_op;
		shift_d = cur_shift;
		sreg_d  = cur_sreg;
		sdata_d = cur_sdata;
		rbyte_d = rbyte_q;
		err_d   = err_q;
		poll_d  = poll_q;
		field_d = field_q;
		scl_d   = scl_q;
		drv_d   = drv_q;
		lvl_d   = lvl_q;
		adv_seg = 1'b0;
		unique case (cur_phase)
			SEG_START: begin
				case (cur_pos)
					5'd0: lvl_d = 1'b1;
					5'd1: drv_d = 1'b1;
					5'd2: scl_d = 1'b1;
					default: lvl_d = 1'b0;
				endcase
				pos_d = cur_pos + 5'd1;
				adv_seg = (cur_pos >= 5'd3);
			end
			SEG_STOP: begin
				case (cur_pos)
					5'd0: drv_d = 1'b1;
					5'd1: lvl_d = 1'b0;
					5'd2: scl_d = 1'b1;
					default: lvl_d = 1'b1;
				endcase
				pos_d = cur_pos + 5'd1;
				adv_seg = (cur_pos >= 5'd3);
			end
			SEG_TXW, SEG_TXR, SEG_TXREG, SEG_TXDATA: begin
				pos_d = cur_pos + 5'd1;
				if (cur_pos == 5'd0) begin
					scl_d = 1'b0;
				end else if (cur_pos == 5'd1) begin
					drv_d = 1'b1;
				end else if (cur_pos < 5'd26) begin
					if (tx_slot.r == 2'd0) begin
						lvl_d = cur_shift[3'd7 - tx_slot.q];
					end else begin
						scl_d = (tx_slot.r == 2'd1);
					end
				end else if (cur_pos == 5'd26) begin
					drv_d = 1'b0;
				end else if (cur_pos == 5'd27) begin
					scl_d = 1'b1;
				end else if (cur_pos == 5'd28) begin
					// The acknowledge wait holds its position while SDA stays high, up to the acknowledge timeout.
					wait_d = cur_wait + 16'd1;
					if (item.sda_in && wait_d <= {6'd0, cfg.ack_timeout}) begin
						pos_d = cur_pos;
					end else if (wait_d >= {6'd0, ack_thr}) begin
						err_d = 1'b1;
					end
				end else begin
					scl_d = 1'b0;
					adv_seg = 1'b1;
				end
			end
			SEG_RX: begin
				pos_d = cur_pos + 5'd1;
				if (cur_pos == 5'd0) begin
					drv_d = 1'b0;
				end else begin
					case (rx_slot.r)
						2'd0: scl_d = 1'b1;
						2'd1: shift_d = {cur_shift[6:0], item.sda_in};
						default: scl_d = 1'b0;
					endcase
				end
				if (cur_pos == 5'd24) begin
					rbyte_d = bcd_to_bin(shift_d);
					adv_seg = 1'b1;
				end
			end
			SEG_SETTLE: begin
				wait_d = cur_wait + 16'd1;
				adv_seg = (wait_d >= cfg.write_settle_ticks);
			end
			SEG_DONE: begin
				if (cur_op == OP_POLL) begin
					field_d = poll_q;
					poll_d  = poll_wrap ? 3'd0 : poll_inc;
				end
				phase_d = SEG_IDLE;
			end
			default: phase_d = SEG_IDLE;
		endcase
		if (adv_seg) begin
			phase_d = next_seg.phase;
			seq_d   = next_seg.seq;
			shift_d = next_seg.shift;
			pos_d   = '0;
			wait_d  = '0;
		end
	end

	always_comb begin
		busy = 1'b0;
		done = 1'b0;
		unique case (cur_phase) inside
			SEG_START, SEG_STOP, SEG_TXW, SEG_TXR, SEG_TXREG, SEG_TXDATA, SEG_RX,
			SEG_SETTLE: busy = 1'b1;
			SEG_DONE: done = 1'b1;
			default: ;
		endcase
		res.scl_level    = scl_d;
		res.sda_drive    = drv_d;
		res.sda_level    = lvl_d;
		res.busy_res     = busy;
		res.done_res     = done;
		res.read_value   = rbyte_d;
		res.field_index  = field_d;
		res.poll_wrapped = done && (cur_op == OP_POLL) && poll_wrap;
		res.ack_error    = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SEG_IDLE;
			seq_q   <= '0;
			pos_q   <= '0;
			wait_q  <= '0;
			op_q    <= OP_TICK;
			shift_q <= '0;
			sreg_q  <= '0;
			sdata_q <= '0;
			rbyte_q <= '0;
			err_q   <= 1'b0;
			poll_q  <= '0;
			field_q <= '0;
			scl_q   <= 1'b1;
			drv_q   <= 1'b0;
			lvl_q   <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			pos_q   <= pos_d;
			wait_q  <= wait_d;
			op_q    <= op_d;
			shift_q <= shift_d;
			sreg_q  <= sreg_d;
			sdata_q <= sdata_d;
			rbyte_q <= rbyte_d;
			err_q   <= err_d;
			poll_q  <= poll_d;
			field_q <= field_d;
			scl_q   <= scl_d;
			drv_q   <= drv_d;
			lvl_q   <= lvl_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == SEG_IDLE |-> pos_q == 5'd0 && wait_q == 16'd0)
		else $error("idle phase with a live position or wait count");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("acknowledge error flag cleared");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'd29)
		else $error("segment position out of range");

	a_poll_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, poll_q} < 4'(FIELD_COUNT))
		else $error("poll rotation index out of range");

endmodule

@@ rtl/core/i2c_rtc_register_master.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// item     in         item_valid / item_stall   item_t: mode, reg_addr, write_data, sda_in
// result   out        result_valid / result_stall  result_t: pins, status, read_value
// config   in         APB psel/penable/pwrite   device_address, ack_timeout, settle ticks
//
// Each accepted item is one bus tick and yields exactly one result, which passes through
// the item register and then the result register. One item per clock is sustained while
// result_stall is low. A stalled result holds while one more item waits in the item
// register; item_stall rises only when both are full. Reset leaves the
// bus master idle with SCL and SDA released and no transfer pending.

module i2c_rtc_register_master #(
	parameter int FIELD_COUNT = i2crtc_pkg::FIELD_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  i2crtc_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output i2crtc_pkg::result_t                 result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [i2crtc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [i2crtc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [i2crtc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                pready
);
	import i2crtc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_res;
	result_t result_q;
	logic    result_valid_q;
	logic    fire, take;

	assign fire       = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !fire;
	assign take       = item_valid && !item_stall;

	i2crtc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2crtc_engine #(
		.FIELD_COUNT (FIELD_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ bench/tb_i2c_rtc_register_master.sv @@
`timescale 1ns / 1ps

module tb_i2c_rtc_register_master;

	import i2crtc_pkg::*;

	typedef enum int {
		ACK_PROMPT,
		ACK_SAFE,
		ACK_ANY,
		ACK_FIXED
	} ack_style_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	i2c_rtc_register_master i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Bus master state as the bench expects it to be.
	logic [6:0]  bm_dev = DEV_ADDR_RST;
	logic [9:0]  bm_ack = ACK_TIMEOUT_RST;
	logic [15:0] bm_settle = SETTLE_RST;
	seg_e        bm_phase = SEG_IDLE;
	logic [2:0]  bm_seq = '0;
	int          bm_pos = 0;
	logic [15:0] bm_wait = '0;
	op_e         bm_op = OP_TICK;
	logic [7:0]  bm_shift = '0;
	logic [7:0]  bm_reg = '0;
	logic [7:0]  bm_data = '0;
	logic [7:0]  bm_byte = '0;
	logic        bm_err = 1'b0;
	logic [2:0]  bm_poll = '0;
	logic [2:0]  bm_field = '0;
	logic        bm_wrap = 1'b0;
	logic        bm_scl = 1'b1;
	logic        bm_drv = 1'b0;
	logic        bm_lvl = 1'b1;

	result_t     tick_outcome_q[$];
	int          mismatch_count = 0;
	bit          calm = 1'b0;
	ack_style_e  ack_style = ACK_PROMPT;
	int          ack_fixed = 0;
	int          ack_delay = 0;
	logic [7:0]  rx_pattern = '0;
	int          stall_left = 0;

	function seg_e leg_of(op_e op, logic [2:0] s);
		if (op == OP_WRITE) begin
			case (s)
				3'd0: return SEG_START;
				3'd1: return SEG_TXW;
				3'd2: return SEG_TXREG;
				3'd3: return SEG_TXDATA;
				3'd4: return SEG_STOP;
				3'd5: return SEG_SETTLE;
				default: return SEG_DONE;
			endcase
		end
		case (s)
			3'd0: return SEG_START;
			3'd1: return SEG_TXW;
			3'd2: return SEG_TXREG;
			3'd3: return SEG_START;
			3'd4: return SEG_TXR;
			3'd5: return SEG_RX;
			3'd6: return SEG_STOP;
			default: return SEG_DONE;
		endcase
	endfunction

	function logic [7:0] rtc_field_reg(logic [2:0] idx);
		case (idx)
			3'd0: return 8'h00;
			3'd1: return 8'h01;
			3'd2: return 8'h02;
			3'd3: return 8'h04;
			3'd4: return 8'h05;
			default: return 8'h06;
		endcase
	endfunction

	function void enter_leg(logic [2:0] s);
		bm_seq = s;
		bm_phase = leg_of(bm_op, s);
		if (bm_phase == SEG_SETTLE && bm_settle == 16'd0) begin
			bm_seq = s + 3'd1;
			bm_phase = leg_of(bm_op, bm_seq);
		end
		bm_pos = 0;
		bm_wait = '0;
		case (bm_phase)
			SEG_TXW: bm_shift = {bm_dev, 1'b0};
			SEG_TXR: bm_shift = {bm_dev, 1'b1};
			SEG_TXREG: bm_shift = bm_reg;
			SEG_TXDATA: bm_shift = bm_data;
			SEG_RX: bm_shift = 8'h00;
			default: ;
		endcase
	endfunction

	function void send_bit_tick(logic sda);
		int b;
		int r;
		int thr;
		bit hold;
		hold = 1'b0;
		if (bm_pos == 0) begin
			bm_scl = 1'b0;
		end else if (bm_pos == 1) begin
			bm_drv = 1'b1;
		end else if (bm_pos < 26) begin
			b = (bm_pos - 2) / 3;
			r = (bm_pos - 2) % 3;
			if (r == 0) bm_lvl = bm_shift[7 - b];
			else bm_scl = (r == 1);
		end else if (bm_pos == 26) begin
			bm_drv = 1'b0;
		end else if (bm_pos == 27) begin
			bm_scl = 1'b1;
		end else if (bm_pos == 28) begin
			thr = (bm_ack == 10'd0) ? 0 : int'(bm_ack) - 1;
			bm_wait = bm_wait + 16'd1;
			if (sda && int'(bm_wait) <= int'(bm_ack)) hold = 1'b1;
			else if (int'(bm_wait) >= thr) bm_err = 1'b1;
		end else begin
			bm_scl = 1'b0;
			enter_leg(bm_seq + 3'd1);
			hold = 1'b1;
		end
		if (!hold) bm_pos++;
	endfunction

	function void receive_bit_tick(logic sda);
		int r;
		if (bm_pos == 0) begin
			bm_drv = 1'b0;
		end else begin
			r = (bm_pos - 1) % 3;
			if (r == 0) bm_scl = 1'b1;
			else if (r == 1) bm_shift = {bm_shift[6:0], sda};
			else bm_scl = 1'b0;
		end
		bm_pos++;
		if (bm_pos == 25) begin
			bm_byte = 8'(int'(bm_shift[7:4]) * 10 + int'(bm_shift[3:0]));
			enter_leg(bm_seq + 3'd1);
		end
	endfunction

	function void edge_tick(bit is_start);
		case (bm_pos)
			0: if (is_start) bm_lvl = 1'b1; else bm_drv = 1'b1;
			1: if (is_start) bm_drv = 1'b1; else bm_lvl = 1'b0;
			2: bm_scl = 1'b1;
			default: bm_lvl = !is_start;
		endcase
		bm_pos++;
		if (bm_pos >= 4) enter_leg(bm_seq + 3'd1);
	endfunction

	function result_t advance_bus_tick(item_t it);
		result_t o;
		logic busy;
		logic done;
		busy = 1'b0;
		done = 1'b0;
		bm_wrap = 1'b0;
		if (bm_phase == SEG_IDLE && it.mode != OP_TICK) begin
			bm_op = op_e'(it.mode);
			bm_reg = it.reg_addr;
			bm_data = it.write_data;
			if (bm_op == OP_POLL && bm_poll >= TIME_FIELDS) begin
				enter_leg(3'd7);
			end else begin
				if (bm_op == OP_POLL) bm_reg = rtc_field_reg(bm_poll);
				enter_leg(3'd0);
			end
		end
		case (bm_phase)
			SEG_START: begin
				busy = 1'b1;
				edge_tick(1'b1);
			end
			SEG_STOP: begin
				busy = 1'b1;
				edge_tick(1'b0);
			end
			SEG_TXW, SEG_TXR, SEG_TXREG, SEG_TXDATA: begin
				busy = 1'b1;
				send_bit_tick(it.sda_in);
			end
			SEG_RX: begin
				busy = 1'b1;
				receive_bit_tick(it.sda_in);
			end
			SEG_SETTLE: begin
				busy = 1'b1;
				bm_wait = bm_wait + 16'd1;
				if (bm_wait >= bm_settle) enter_leg(bm_seq + 3'd1);
			end
			SEG_DONE: begin
				done = 1'b1;
				if (bm_op == OP_POLL) begin
					bm_field = bm_poll;
					bm_poll = bm_poll + 3'd1;
					if (bm_poll >= FIELD_COUNT || bm_poll == 3'd0) begin
						bm_poll = '0;
						bm_wrap = 1'b1;
					end
				end
				bm_phase = SEG_IDLE;
			end
			default: bm_phase = SEG_IDLE;
		endcase
		o.scl_level = bm_scl;
		o.sda_drive = bm_drv;
		o.sda_level = bm_lvl;
		o.busy_res = busy;
		o.done_res = done;
		o.read_value = bm_byte;
		o.field_index = bm_field;
		o.poll_wrapped = bm_wrap;
		o.ack_error = bm_err;
		return o;
	endfunction

	function int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function int choose_ack_delay();
		int lim;
		int r;
		lim = int'(bm_ack) - 3;
		if (lim < 0) lim = 0;
		r = $urandom_range(0, 19);
		case (ack_style)
			ACK_FIXED: return ack_fixed;
			ACK_SAFE: begin
				if (r < 16) return $urandom_range(0, (lim < 2) ? lim : 2);
				return $urandom_range(0, lim);
			end
			ACK_ANY: begin
				if (r < 12) return $urandom_range(0, 2);
				if (r < 17) return $urandom_range(0, int'(bm_ack) + 1);
				return -1;
			end
			default: return 0;
		endcase
	endfunction

	// The target answers acknowledges and read bits according to the bus state.
	function logic pick_sda();
		if (bm_phase inside {SEG_TXW, SEG_TXR, SEG_TXREG, SEG_TXDATA} && bm_pos == 28) begin
			if (bm_wait == 16'd0) ack_delay = choose_ack_delay();
			return (ack_delay < 0 || int'(bm_wait) < ack_delay);
		end
		if (bm_phase == SEG_RX && bm_pos >= 1 && (bm_pos - 1) % 3 == 1)
			return rx_pattern[7 - (bm_pos - 1) / 3];
		return 1'($urandom_range(0, 1));
	endfunction

	function logic [7:0] rtc_byte();
		if ($urandom_range(0, 1)) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
		return 8'($urandom);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (calm || $urandom_range(0, 2) != 0) begin
			result_stall <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			result_stall <= 1'b1;
			stall_left = gap_len() - 1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (tick_outcome_q.size() == 0) begin
				$error("result transfer with no expected tick outcome");
				mismatch_count++;
			end else begin
				want = tick_outcome_q.pop_front();
				compare_field("scl_level", want.scl_level, result.scl_level);
				compare_field("sda_drive", want.sda_drive, result.sda_drive);
				compare_field("sda_level", want.sda_level, result.sda_level);
				compare_field("busy_res", want.busy_res, result.busy_res);
				compare_field("done_res", want.done_res, result.done_res);
				compare_field("read_value", want.read_value, result.read_value);
				compare_field("field_index", want.field_index, result.field_index);
				compare_field("poll_wrapped", want.poll_wrapped, result.poll_wrapped);
				compare_field("ack_error", want.ack_error, result.ack_error);
			end
		end
	end

	task automatic push_tick(item_t it);
		int n;
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		tick_outcome_q.push_back(advance_bus_tick(it));
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = gap_len();
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain_ticks();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tick_outcome_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(reg_e idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_ADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEVICE_ADDRESS: bm_dev = value[6:0];
			REG_ACK_TIMEOUT: bm_ack = value[9:0];
			default: bm_settle = value[15:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [6:0] dev, logic [9:0] ack, logic [15:0] settle);
		drain_ticks();
		apb_write(REG_DEVICE_ADDRESS, 32'(dev));
		apb_write(REG_ACK_TIMEOUT, 32'(ack));
		apb_write(REG_SETTLE_TICKS, 32'(settle));
	endtask

	task automatic idle_tick();
		item_t it;
		it.mode = OP_TICK;
		it.reg_addr = 8'($urandom);
		it.write_data = 8'($urandom);
		it.sda_in = 1'($urandom_range(0, 1));
		push_tick(it);
	endtask

	// One bus transfer from its command tick to its done tick; commands seen while
	// busy are thrown in as noise.
	task automatic run_transfer(op_e op, logic [7:0] ra, logic [7:0] wd, logic [7:0] rx);
		item_t it;
		rx_pattern = rx;
		repeat ($urandom_range(0, 2)) idle_tick();
		it.mode = op;
		it.reg_addr = ra;
		it.write_data = wd;
		it.sda_in = 1'($urandom_range(0, 1));
		push_tick(it);
		while (bm_phase != SEG_IDLE) begin
			it.mode = ($urandom_range(0, 7) == 0) ? op_e'($urandom_range(1, 3)) : OP_TICK;
			it.reg_addr = 8'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = pick_sda();
			push_tick(it);
		end
	endtask

	task automatic random_phase(int count, bit clean);
		logic [6:0] dev;
		logic [9:0] ack;
		logic [15:0] settle;
		int pick;
		pick = $urandom_range(0, 3);
		dev = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom);
		pick = $urandom_range(0, 3);
		if (clean)
			ack = (pick == 0) ? 10'd3 : 10'($urandom_range(3, 12));
		else
			ack = (pick == 0) ? 10'd1 : 10'($urandom_range(1, 12));
		pick = $urandom_range(0, 3);
		settle = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
			(pick == 2) ? 16'($urandom_range(2, 8)) : 16'($urandom_range(9, 20));
		set_config(dev, ack, settle);
		calm = ($urandom_range(0, 3) == 0);
		ack_style = clean ? ACK_SAFE : ACK_ANY;
		repeat (count)
			run_transfer(op_e'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), rtc_byte());
	endtask

	task automatic check_idle_pins();
		repeat (6) idle_tick();
	endtask

	// A read under the reset configuration with a two-digit BCD byte.
	task automatic check_read_bcd();
		ack_style = ACK_PROMPT;
		run_transfer(OP_READ, 8'h12, 8'h00, 8'h59);
	endtask

	task automatic check_config_extremes();
		ack_style = ACK_PROMPT;
		set_config(7'd127, 10'd1023, 16'd0);
		run_transfer(OP_WRITE, 8'hA5, 8'h5A, 8'h00);
		set_config(7'd0, 10'd3, 16'd1);
		run_transfer(OP_POLL, 8'hC3, 8'hFF, 8'h7E);
	endtask

	// Acknowledge arrives on the last wait tick that still counts as in time.
	task automatic check_ack_margin();
		set_config(7'h2A, 10'd5, 16'd2);
		ack_style = ACK_FIXED;
		ack_fixed = 2;
		run_transfer(OP_WRITE, 8'h0F, 8'hF0, 8'h00);
	endtask

	task automatic check_ack_timeout();
		set_config(DEV_ADDR_RST, 10'd2, 16'd0);
		ack_style = ACK_FIXED;
		ack_fixed = 0;
		run_transfer(OP_WRITE, 8'h01, 8'h23, 8'h00);
	endtask

	task automatic check_random_full();
		random_phase(1, 1'b0);
	endtask

	initial begin
		wait (arst_n === 1'b1);
		check_idle_pins();
		check_read_bcd();
		check_config_extremes();
		check_ack_margin();
		check_ack_timeout();
		check_random_full();
		drain_ticks();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/i2crtc_pkg.sv
rtl/core/i2crtc_cfg.sv
rtl/core/i2crtc_engine.sv
rtl/core/i2c_rtc_register_master.sv
bench/tb_i2c_rtc_register_master.sv
